@@ rtl/core/msc_pkg.sv @@
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types, command and register codes, and the per-channel range test
// for the multi-sample colour range segmenter.
// ----------------------------------------------------------------------------
package msc_pkg;

    typedef logic [7:0]  chan_t;
    // Lab colour: channel 0 (L) in 7:0, channel 1 (a) in 15:8, channel 2 (b) in 23:16
    typedef logic [23:0] lab_t;

    localparam int CHANNELS  = 3;
    localparam int CMD_W     = 2;
    localparam int SLOT_W    = 3;
    localparam int CFG_IDX_W = 8;

    localparam logic [CMD_W-1:0] CMD_CLASSIFY  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_HAND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD_BACK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_HAND_LOWER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HAND_UPPER = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_LOWER = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_UPPER = 8'd3;

    localparam lab_t HAND_MARGIN_RST = 24'h0A0A32;
    localparam lab_t BACK_MARGIN_RST = 24'h030332;

    // sample load request, from the input beat to the sample store
    typedef struct packed {
        logic              hand_we;
        logic              back_we;
        logic [SLOT_W-1:0] slot;
        lab_t              color;
    } load_req_t;

    // p within [max(0, s - ml), min(255, s + mu)]
    function automatic logic chan_in_range(chan_t p, chan_t s, chan_t ml, chan_t mu);
        logic [8:0] lo_diff;
        logic [8:0] hi_sum;
        chan_t      lo;
        chan_t      hi;
        lo_diff = {1'b0, s} - {1'b0, ml};
        hi_sum  = {1'b0, s} + {1'b0, mu};
        lo      = lo_diff[8] ? 8'h00 : lo_diff[7:0];
        hi      = hi_sum[8]  ? 8'hFF : hi_sum[7:0];
        return (p >= lo) && (p <= hi);
    endfunction

endpackage

@@ rtl/core/msc_sample_store.sv @@
// ----------------------------------------------------------------------------
// msc_sample_store
// Hand and background sample registers, written by load beats.
// ----------------------------------------------------------------------------
module msc_sample_store #(
    parameter int SAMPLES = 7
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  msc_pkg::load_req_t               load,
    output logic [SAMPLES-1:0][23:0]         hand_samples,
    output logic [SAMPLES-1:0][23:0]         back_samples
);

    logic [SAMPLES-1:0][23:0] hand_reg;
    logic [SAMPLES-1:0][23:0] back_reg;
    logic [SAMPLES-1:0][23:0] hand_next;
    logic [SAMPLES-1:0][23:0] back_next;

    always_comb begin
        hand_next = hand_reg;
        back_next = back_reg;
        for (int i = 0; i < SAMPLES; i++) begin
            // slot beyond the store never matches and the load is dropped
            if (5'(load.slot) == 5'(i)) begin
                if (load.hand_we) begin
                    hand_next[i] = load.color;
                end
                if (load.back_we) begin
                    back_next[i] = load.color;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hand_reg <= '0;
            back_reg <= '0;
        end else begin
            hand_reg <= hand_next;
            back_reg <= back_next;
        end
    end

    assign hand_samples = hand_reg;
    assign back_samples = back_reg;

endmodule

@@ rtl/core/msc_range_match.sv @@
// ----------------------------------------------------------------------------
// msc_range_match
// Compare stage: registers one in-range bit per sample and channel.
// ----------------------------------------------------------------------------
module msc_range_match #(
    parameter int SAMPLES = 7
) (
    input  logic                                       aclk,
    input  logic                                       en,
    input  msc_pkg::lab_t                              pixel,
    input  logic [SAMPLES-1:0][23:0]                   samples,
    input  msc_pkg::lab_t                              lower_margin,
    input  msc_pkg::lab_t                              upper_margin,
    output logic [SAMPLES-1:0][msc_pkg::CHANNELS-1:0]  match
);

    logic [SAMPLES-1:0][msc_pkg::CHANNELS-1:0] match_reg;
    logic [SAMPLES-1:0][msc_pkg::CHANNELS-1:0] match_next;

    always_comb begin
        for (int i = 0; i < SAMPLES; i++) begin
            for (int c = 0; c < msc_pkg::CHANNELS; c++) begin
                match_next[i][c] = msc_pkg::chan_in_range(
                    pixel[8*c +: 8], samples[i][8*c +: 8],
                    lower_margin[8*c +: 8], upper_margin[8*c +: 8]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

@@ rtl/core/msc_hit_reduce.sv @@
// ----------------------------------------------------------------------------
// msc_hit_reduce
// Reduce stage: all channels of a sample, then any sample of each set.
// ----------------------------------------------------------------------------
module msc_hit_reduce #(
    parameter int SAMPLES = 7
) (
    input  logic                                       aclk,
    input  logic                                       en,
    input  logic [SAMPLES-1:0][msc_pkg::CHANNELS-1:0]  hand_match,
    input  logic [SAMPLES-1:0][msc_pkg::CHANNELS-1:0]  back_match,
    output logic                                       hand_hit,
    output logic                                       back_hit
);

    logic hand_hit_reg;
    logic back_hit_reg;
    logic hand_hit_next;
    logic back_hit_next;

    always_comb begin
        hand_hit_next = 1'b0;
        back_hit_next = 1'b0;
        for (int i = 0; i < SAMPLES; i++) begin
            hand_hit_next = hand_hit_next | (&hand_match[i]);
            back_hit_next = back_hit_next | (&back_match[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hand_hit_reg <= hand_hit_next;
            back_hit_reg <= back_hit_next;
        end
    end

    assign hand_hit = hand_hit_reg;
    assign back_hit = back_hit_reg;

endmodule

@@ rtl/core/multi_sample_color_range_segmenter_top.sv @@
// An accepted classify beat passes the input register, compare stage, reduce stage
// and output register before it reaches m_tvalid. Throughput: one beat per cycle;
// each stage holds only while every stage behind it is full and m_tready is low.
// Load beats update the sample store on acceptance and give no result.
// Reset (aresetn low, synchronous) empties the pipeline, zeroes all samples and
// restores the default margins.
// ----------------------------------------------------------------------------
// multi_sample_color_range_segmenter_top
// Classifies Lab pixels against stored hand and background colour samples.
// ----------------------------------------------------------------------------
module multi_sample_color_range_segmenter_top #(
    parameter int SAMPLES = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // slot[2:0], chan_l[10:3],
                                                      // chan_a[18:11], chan_b[26:19], 0
    input  logic [1:0]                     s_tuser,   // cmd[1:0]

    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // mask[0], hand_hit[1],
                                                      // back_hit[2], 0

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [msc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [23:0]                    cfg_data
);

    // ---------------- configuration ----------------
    msc_pkg::lab_t hand_lower_reg, hand_upper_reg, back_lower_reg, back_upper_reg;
    msc_pkg::lab_t hand_lower_next, hand_upper_next, back_lower_next, back_upper_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        hand_lower_next = hand_lower_reg;
        hand_upper_next = hand_upper_reg;
        back_lower_next = back_lower_reg;
        back_upper_next = back_upper_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                msc_pkg::REG_HAND_LOWER: hand_lower_next = cfg_data;
                msc_pkg::REG_HAND_UPPER: hand_upper_next = cfg_data;
                msc_pkg::REG_BACK_LOWER: back_lower_next = cfg_data;
                msc_pkg::REG_BACK_UPPER: back_upper_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hand_lower_reg <= msc_pkg::HAND_MARGIN_RST;
            hand_upper_reg <= msc_pkg::HAND_MARGIN_RST;
            back_lower_reg <= msc_pkg::BACK_MARGIN_RST;
            back_upper_reg <= msc_pkg::BACK_MARGIN_RST;
        end else begin
            hand_lower_reg <= hand_lower_next;
            hand_upper_reg <= hand_upper_next;
            back_lower_reg <= back_lower_next;
            back_upper_reg <= back_upper_next;
        end
    end

    // ---------------- input decode ----------------
    logic [msc_pkg::CMD_W-1:0]  in_cmd;
    logic [msc_pkg::SLOT_W-1:0] in_slot;
    msc_pkg::lab_t              in_color;
    logic                       in_beat;
    logic                       in_classify;
    msc_pkg::load_req_t         load;

    assign in_cmd   = s_tuser;
    assign in_slot  = s_tdata[2:0];
    assign in_color = s_tdata[26:3];
    assign in_beat  = s_tvalid && s_tready;

    always_comb begin
        in_classify  = 1'b0;
        load.hand_we = 1'b0;
        load.back_we = 1'b0;
        load.slot    = in_slot;
        load.color   = in_color;
        unique case (in_cmd)
            msc_pkg::CMD_CLASSIFY:  in_classify  = in_beat;
            msc_pkg::CMD_LOAD_HAND: load.hand_we = in_beat;
            msc_pkg::CMD_LOAD_BACK: load.back_we = in_beat;
            default: ;
        endcase
    end

    // ---------------- pipeline control ----------------
    // Ready ripples back so bubbles collapse. While a pixel waits in stage 1, a load
    // is only taken when the compare stage captures in the same edge, so the compare
    // always sees the samples as they stood when its pixel was accepted.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign s_tready = !v1_reg || rdy2;

    always_comb begin
        v1_next = s_tready ? in_classify : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        v4_next = rdy4 ? v3_reg : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // ---------------- stage 1: pixel register ----------------
    msc_pkg::lab_t pixel_reg;

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            pixel_reg <= in_color;
        end
    end

    // ---------------- sample store ----------------
    logic [SAMPLES-1:0][23:0] hand_samples;
    logic [SAMPLES-1:0][23:0] back_samples;

    msc_sample_store #(.SAMPLES(SAMPLES)) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .hand_samples (hand_samples),
        .back_samples (back_samples)
    );

    // ---------------- stage 2: range compare ----------------
    logic [SAMPLES-1:0][msc_pkg::CHANNELS-1:0] hand_match;
    logic [SAMPLES-1:0][msc_pkg::CHANNELS-1:0] back_match;

    msc_range_match #(.SAMPLES(SAMPLES)) u_hand_match (
        .aclk         (aclk),
        .en           (rdy2),
        .pixel        (pixel_reg),
        .samples      (hand_samples),
        .lower_margin (hand_lower_reg),
        .upper_margin (hand_upper_reg),
        .match        (hand_match)
    );

    msc_range_match #(.SAMPLES(SAMPLES)) u_back_match (
        .aclk         (aclk),
        .en           (rdy2),
        .pixel        (pixel_reg),
        .samples      (back_samples),
        .lower_margin (back_lower_reg),
        .upper_margin (back_upper_reg),
        .match        (back_match)
    );

    // ---------------- stage 3: reduce ----------------
    logic hand_hit;
    logic back_hit;

    msc_hit_reduce #(.SAMPLES(SAMPLES)) u_reduce (
        .aclk       (aclk),
        .en         (rdy3),
        .hand_match (hand_match),
        .back_match (back_match),
        .hand_hit   (hand_hit),
        .back_hit   (back_hit)
    );

    // ---------------- stage 4: output register ----------------
    logic [2:0] result_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            result_reg <= {back_hit, hand_hit, hand_hit && !back_hit};
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {5'b0, result_reg};

    // ---------------- assertions ----------------
    a_mask_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[1] && !m_tdata[2])))
        else $error("mask disagrees with hand and background hits");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_stage1_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !rdy2) |=> (v1_reg && $stable(pixel_reg)))
        else $error("stalled pixel lost or changed");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> (!v1_reg && !v2_reg && !v3_reg && !m_tvalid))
        else $error("pipeline not empty after reset");

endmodule

@@ tb/segmenter_mask_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmenter_mask_checker
// Watches the pixel, result and margin-register channels of the colour range
// segmenter. It keeps its own copy of the margins and both sample stores,
// predicts mask and hit flags for every classify beat, and compares each
// result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module segmenter_mask_checker
    import msc_pkg::*;
#(
    parameter int SAMPLES = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [31:0]          s_tdata,
    input  logic [1:0]           s_tuser,

    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]          cfg_data,

    output int                   mismatches,
    output int                   outstanding
);

    // bit 0 mask, bit 1 hand hit, bit 2 background hit, as on m_tdata
    typedef struct packed {
        logic back_hit;
        logic hand_hit;
        logic mask;
    } verdict_t;

    lab_t hand_lo_m, hand_hi_m, back_lo_m, back_hi_m;
    lab_t hand_set [SAMPLES];
    lab_t back_set [SAMPLES];

    verdict_t verdict_q [$];
    verdict_t got, want;
    lab_t     px;
    logic [SLOT_W-1:0] slot;
    int       errs = 0;

    // Signed bounds: clamping to 0..255 cannot change the outcome for an
    // 8-bit pixel, so the plain compare is enough.
    function automatic logic chan_fits(chan_t p, chan_t s, chan_t ml, chan_t mu);
        int lo;
        int hi;
        lo = int'(s) - int'(ml);
        hi = int'(s) + int'(mu);
        return (int'(p) >= lo) && (int'(p) <= hi);
    endfunction

    function automatic logic colour_in_set(lab_t colour, logic from_back);
        lab_t smp;
        lab_t ml;
        lab_t mu;
        logic all_fit;
        logic hit;
        hit = 1'b0;
        ml  = from_back ? back_lo_m : hand_lo_m;
        mu  = from_back ? back_hi_m : hand_hi_m;
        for (int i = 0; i < SAMPLES; i++) begin
            smp     = from_back ? back_set[i] : hand_set[i];
            all_fit = 1'b1;
            for (int c = 0; c < CHANNELS; c++)
                if (!chan_fits(colour[8*c +: 8], smp[8*c +: 8], ml[8*c +: 8], mu[8*c +: 8]))
                    all_fit = 1'b0;
            if (all_fit)
                hit = 1'b1;
        end
        return hit;
    endfunction

    function automatic verdict_t predict_verdict(lab_t colour);
        verdict_t v;
        v.hand_hit = colour_in_set(colour, 1'b0);
        v.back_hit = colour_in_set(colour, 1'b1);
        v.mask     = v.hand_hit & ~v.back_hit;
        return v;
    endfunction

    function automatic int field_mismatch(string name, logic exp_bit, logic act_bit);
        if (exp_bit === act_bit)
            return 0;
        $display("%0t: %s expected %0b, got %0b", $time, name, exp_bit, act_bit);
        return 1;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            hand_lo_m = HAND_MARGIN_RST;
            hand_hi_m = HAND_MARGIN_RST;
            back_lo_m = BACK_MARGIN_RST;
            back_hi_m = BACK_MARGIN_RST;
            for (int i = 0; i < SAMPLES; i++) begin
                hand_set[i] = '0;
                back_set[i] = '0;
            end
            verdict_q.delete();
        end else begin
            // results leave only after their pixel has passed the pipeline registers, so pop first
            if (m_tvalid && m_tready) begin
                got = verdict_t'(m_tdata[2:0]);
                if (verdict_q.size() == 0) begin
                    errs++;
                    $display("%0t: result beat with nothing expected, mask %0b hand %0b back %0b",
                             $time, got.mask, got.hand_hit, got.back_hit);
                end else begin
                    want = verdict_q.pop_front();
                    errs += field_mismatch("mask", want.mask, got.mask);
                    errs += field_mismatch("hand_hit", want.hand_hit, got.hand_hit);
                    errs += field_mismatch("back_hit", want.back_hit, got.back_hit);
                end
            end

            if (s_tvalid && s_tready) begin
                slot = s_tdata[SLOT_W-1:0];
                px   = s_tdata[SLOT_W +: 24];
                case (s_tuser)
                    CMD_CLASSIFY:  verdict_q = {verdict_q, predict_verdict(px)};
                    CMD_LOAD_HAND: if (slot < SAMPLES) hand_set[slot] = px;
                    CMD_LOAD_BACK: if (slot < SAMPLES) back_set[slot] = px;
                    default: ;
                endcase
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_HAND_LOWER: hand_lo_m = cfg_data;
                    REG_HAND_UPPER: hand_hi_m = cfg_data;
                    REG_BACK_LOWER: back_lo_m = cfg_data;
                    REG_BACK_UPPER: back_hi_m = cfg_data;
                    default: ;
                endcase
            end
        end
        mismatches  <= errs;
        outstanding <= verdict_q.size();
    end

endmodule

@@ tb/tb_multi_sample_color_range_segmenter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_sample_color_range_segmenter_top
// Loads hand and background samples, sweeps the margin registers through
// several settings and classifies pixels aimed at the range bounds, with
// random gaps on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_multi_sample_color_range_segmenter_top;
    import msc_pkg::*;

    localparam int N_SAMPLES       = 7;
    localparam int LATENCY         = 4;
    localparam int SETTLE_CYCLES   = 2 * LATENCY;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_LIMIT      = 4000;

    localparam logic [CMD_W-1:0]     CMD_SPARE     = 2'd3;
    localparam logic [SLOT_W-1:0]    SLOT_PAST_END = 3'd7;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic [1:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [23:0]          cfg_data  = '0;

    int mismatches;
    int outstanding;

    // what the stimulus believes is loaded, used only to aim pixels
    lab_t aim_hand [N_SAMPLES];
    lab_t aim_back [N_SAMPLES];
    lab_t aim_hl = HAND_MARGIN_RST;
    lab_t aim_hu = HAND_MARGIN_RST;
    lab_t aim_bl = BACK_MARGIN_RST;
    lab_t aim_bu = BACK_MARGIN_RST;

    int   calm_left     = 0;
    logic hold_off_req  = 1'b0;
    logic hold_off_done = 1'b0;
    int   hold_left     = 0;
    int   rx_left       = 0;
    logic rx_on         = 1'b0;
    int   idle_cycles   = 0;

    always #4 aclk = ~aclk;

    multi_sample_color_range_segmenter_top #(
        .SAMPLES (N_SAMPLES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    segmenter_mask_checker #(
        .SAMPLES (N_SAMPLES)
    ) u_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic lab_t mk_lab(chan_t l, chan_t a, chan_t b);
        return {b, a, l};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int run_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 8);
        if (r < 95) return $urandom_range(9, 30);
        return $urandom_range(60, 150);
    endfunction

    function automatic lab_t random_margin(int top_val);
        lab_t m;
        for (int c = 0; c < CHANNELS; c++)
            m[8*c +: 8] = chan_t'($urandom_range(0, top_val));
        return m;
    endfunction

    // pixel near a sample, often right on a bound or one step outside it
    function automatic lab_t near_colour(lab_t base, lab_t lo_m, lab_t hi_m);
        lab_t c;
        int   lo;
        int   hi;
        int   v;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            lo = int'(base[8*ch +: 8]) - int'(lo_m[8*ch +: 8]);
            hi = int'(base[8*ch +: 8]) + int'(hi_m[8*ch +: 8]);
            case ($urandom_range(0, 5))
                0:       v = lo - int'($urandom_range(0, 1));
                1:       v = hi + int'($urandom_range(0, 1));
                default: v = int'($urandom_range(0, hi - lo + 4)) + lo - 2;
            endcase
            if (v < 0)   v = 0;
            if (v > 255) v = 255;
            c[8*ch +: 8] = chan_t'(v);
        end
        return c;
    endfunction

    task automatic push_beat(logic [CMD_W-1:0] op, logic [SLOT_W-1:0] slot, lab_t colour);
        int gap;
        gap = (calm_left > 0) ? 0 : pick_gap();
        if (calm_left > 0)
            calm_left--;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, colour, slot};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic load_sample(logic [CMD_W-1:0] op, logic [SLOT_W-1:0] slot, lab_t colour);
        push_beat(op, slot, colour);
        if (slot < N_SAMPLES) begin
            if (op == CMD_LOAD_HAND)
                aim_hand[slot] = colour;
            else if (op == CMD_LOAD_BACK)
                aim_back[slot] = colour;
        end
    endtask

    task automatic classify(lab_t colour);
        push_beat(CMD_CLASSIFY, SLOT_W'($urandom), colour);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, lab_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_HAND_LOWER: aim_hl = value;
            REG_HAND_UPPER: aim_hu = value;
            REG_BACK_LOWER: aim_bl = value;
            REG_BACK_UPPER: aim_bu = value;
            default: ;
        endcase
    endtask

    // stop sending, let every result drain, then give the pipe time to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_margins(lab_t hl, lab_t hu, lab_t bl, lab_t bu, logic with_junk);
        settle();
        write_reg(REG_HAND_LOWER, hl);
        write_reg(REG_HAND_UPPER, hu);
        write_reg(REG_BACK_LOWER, bl);
        if (with_junk) begin
            write_reg(CFG_IDX_W'($urandom_range(4, 254)), lab_t'($urandom));
            write_reg(REG_TOP_INDEX, lab_t'($urandom));
        end
        write_reg(REG_BACK_UPPER, bu);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_items(int n, int hold_at);
        int r;
        for (int k = 0; k < N_SAMPLES; k++) begin
            load_sample(CMD_LOAD_HAND, SLOT_W'(k), lab_t'($urandom));
            load_sample(CMD_LOAD_BACK, SLOT_W'(k), lab_t'($urandom));
        end
        for (int i = 0; i < n; i++) begin
            if (i == hold_at)
                hold_off_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 45)
                classify(near_colour(aim_hand[$urandom_range(0, N_SAMPLES-1)], aim_hl, aim_hu));
            else if (r < 65)
                classify(near_colour(aim_back[$urandom_range(0, N_SAMPLES-1)], aim_bl, aim_bu));
            else if (r < 73)
                classify(lab_t'($urandom));
            else if (r < 83)
                load_sample(CMD_LOAD_HAND, SLOT_W'($urandom_range(0, N_SAMPLES-1)),
                            lab_t'($urandom));
            else if (r < 88)
                // background sample overlapping a hand sample, to get masked-out hits
                load_sample(CMD_LOAD_BACK, SLOT_W'($urandom_range(0, N_SAMPLES-1)),
                            near_colour(aim_hand[$urandom_range(0, N_SAMPLES-1)],
                                        aim_hl, aim_hu));
            else if (r < 93)
                load_sample(CMD_LOAD_BACK, SLOT_W'($urandom_range(0, N_SAMPLES-1)),
                            lab_t'($urandom));
            else if (r < 97)
                load_sample($urandom_range(0, 1) ? CMD_LOAD_HAND : CMD_LOAD_BACK,
                            SLOT_PAST_END, lab_t'($urandom));
            else
                push_beat(CMD_SPARE, SLOT_W'($urandom), lab_t'($urandom));
        end
    endtask

    // output side: random ready/stall windows plus one long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_on     = 1'b0;
            rx_left   = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            if (hold_left == 0) begin
                m_tready <= 1'b1;
                rx_on     = 1'b1;
                rx_left   = run_length() - 1;
            end
        end else if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left     = HOLD_OFF_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_left > 0) begin
            rx_left--;
        end else begin
            if (rx_on) begin
                rx_left = pick_gap();
                if (rx_left == 0) begin
                    rx_left = run_length();
                end else begin
                    m_tready <= 1'b0;
                    rx_on     = 1'b0;
                end
            end else begin
                rx_left   = run_length();
                m_tready <= 1'b1;
                rx_on     = 1'b1;
            end
            rx_left--;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < N_SAMPLES; k++) begin
            aim_hand[k] = '0;
            aim_back[k] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // reset margins: hand (50,10,10), background (50,3,3), stores all zero
        classify(mk_lab(0, 0, 0));
        push_beat(CMD_CLASSIFY, SLOT_PAST_END, mk_lab(255, 255, 255));
        load_sample(CMD_LOAD_HAND, 3'd0, mk_lab(100, 128, 128));
        load_sample(CMD_LOAD_HAND, 3'd6, mk_lab(255, 255, 255));
        load_sample(CMD_LOAD_HAND, SLOT_PAST_END, mk_lab(1, 2, 3));
        load_sample(CMD_LOAD_BACK, SLOT_PAST_END, mk_lab(255, 255, 255));
        push_beat(CMD_SPARE, SLOT_PAST_END, mk_lab(255, 255, 255));
        classify(mk_lab(100, 128, 128));
        classify(mk_lab(50, 118, 118));
        classify(mk_lab(49, 118, 118));
        classify(mk_lab(150, 138, 138));
        classify(mk_lab(150, 139, 138));
        classify(mk_lab(205, 245, 245));
        classify(mk_lab(204, 245, 245));
        classify(mk_lab(255, 255, 255));
        load_sample(CMD_LOAD_BACK, 3'd3, mk_lab(100, 128, 131));
        classify(mk_lab(100, 128, 128));
        classify(mk_lab(100, 128, 127));
        load_sample(CMD_LOAD_BACK, 3'd6, mk_lab(255, 255, 255));
        classify(mk_lab(255, 255, 255));
        classify(mk_lab(0, 255, 0));
        classify(mk_lab(50, 3, 3));
        random_items(150, -1);

        // exact match only
        set_margins('0, '0, '0, '0, 1'b0);
        calm_left = 60;
        random_items(150, -1);

        // everything matches everything
        set_margins('1, '1, '1, '1, 1'b1);
        random_items(120, -1);

        set_margins(random_margin(40), random_margin(40), random_margin(12),
                    random_margin(12), 1'b0);
        random_items(200, 60);

        set_margins(lab_t'($urandom), lab_t'($urandom), random_margin(8),
                    random_margin(8), 1'b1);
        calm_left = 80;
        random_items(150, -1);

        set_margins(random_margin(255), random_margin(255), '0, random_margin(20), 1'b1);
        random_items(150, -1);

        settle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
